[hdl/svmsk_pkg.sv]
// ----------------------------------------------------------------------------
// svmsk_pkg
// Shared types, constants and the tanh table of the sigmoid-kernel SVM block.
// ----------------------------------------------------------------------------
package svmsk_pkg;

  localparam int MAX_VECTORS     = 64;
  localparam int MAX_FEATURES    = 256;
  localparam int TANH_TABLE_SIZE = 256;

  localparam int VEC_W   = $clog2(MAX_VECTORS);
  localparam int FEAT_W  = $clog2(MAX_FEATURES);
  localparam int VS_AW   = VEC_W + FEAT_W;
  localparam int CNT_W   = VEC_W + 1;
  localparam int TIDX_W  = $clog2(TANH_TABLE_SIZE);
  localparam int FRAC_W  = 19 - TIDX_W;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = 56;

  localparam logic [1:0] OP_LOAD_VEC  = 2'd0;
  localparam logic [1:0] OP_LOAD_COEF = 2'd1;
  localparam logic [1:0] OP_FEATURE   = 2'd2;
  localparam logic [1:0] OP_RESERVED  = 2'd3;

  localparam logic [1:0] REG_BIAS   = 2'd0;
  localparam logic [1:0] REG_GAMMA  = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_NVEC   = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         vector_index;
    logic [7:0]         feature_index;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] decision;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_WAIT,
    ST_DEC,
    ST_DEC_WAIT
  } state_t;

  typedef struct packed {
    logic                    vs_we;
    logic [VS_AW-1:0]        vs_waddr;
    logic [15:0]             vs_wdata;
    logic                    mac_issue;
    logic [VEC_W-1:0]        mac_v;
    logic [FEAT_W-1:0]       mac_fi;
    logic signed [15:0]      mac_x;
    logic [VEC_W-1:0]        rd_v;
    logic                    clear;
  } dot_ctl_t;

  typedef struct packed {
    logic                    coef_we;
    logic [VEC_W-1:0]        coef_waddr;
    logic [31:0]             coef_wdata;
    logic                    init;
    logic                    issue;
    logic [VEC_W-1:0]        v;
  } kern_ctl_t;

  typedef logic [16:0] tanh_tbl_t [0:TANH_TABLE_SIZE];

  // Q2.30 series for tanh(h), h = 8 / TANH_TABLE_SIZE
  localparam longint TANH_H  = (longint'(8) <<< 30) / TANH_TABLE_SIZE;
  localparam longint TANH_H2 = (TANH_H * TANH_H) >>> 30;
  localparam longint TANH_H3 = (TANH_H2 * TANH_H) >>> 30;
  localparam longint TANH_H5 = (TANH_H3 * TANH_H2) >>> 30;
  localparam longint TANH_H7 = (TANH_H5 * TANH_H2) >>> 30;
  localparam longint TANH_H9 = (TANH_H7 * TANH_H2) >>> 30;
  localparam longint TANH_TH = TANH_H - TANH_H3 / 3 + (2 * TANH_H5) / 15
                               - (17 * TANH_H7) / 315 + (62 * TANH_H9) / 2835;

  // Restoring long division of non-negative operands, truncating.
  function automatic longint div_u63(longint num, longint den);
    longint quo, rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return quo;
  endfunction

  // Q1.16 table over [0, 8]: step by the addition formula from tanh(h).
  function automatic tanh_tbl_t build_tanh();
    tanh_tbl_t tb;
    longint t, den;
    t  = 0;
    tb[0] = '0;
    for (int k = 1; k <= TANH_TABLE_SIZE; k++) begin
      den   = (longint'(1) <<< 30) + ((t * TANH_TH) >>> 30);
      t     = div_u63((t + TANH_TH) <<< 30, den);
      tb[k] = 17'((t + 8192) >>> 14);
    end
    return tb;
  endfunction

  localparam tanh_tbl_t TANH_TBL = build_tanh();

endpackage

[hdl/svmsk_dot_unit.sv]
// ----------------------------------------------------------------------------
// svmsk_dot_unit
// Support-vector store and dot-product accumulators with the MAC pipeline.
// ----------------------------------------------------------------------------
module svmsk_dot_unit import svmsk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dot_ctl_t                ctl,
  output logic signed [ACC_W-1:0] acc_rd,
  output logic                    pipe_busy
);

  logic [15:0]             vs_mem [0:MAX_VECTORS*MAX_FEATURES-1];
  logic [ACC_W-1:0]        acc_mem [0:MAX_VECTORS-1];
  logic [MAX_VECTORS-1:0]  acc_vld_r;

  logic signed [15:0]      vs_q;
  logic [ACC_W-1:0]        acc_q;
  logic                    acc_q_vld;

  logic                    s1_vld_r, s2_vld_r;
  logic [VEC_W-1:0]        s1_v_r, s2_v_r;
  logic signed [15:0]      x_r;
  logic signed [31:0]      prod_r;
  logic [VEC_W-1:0]        acc_raddr;
  logic [ACC_W-1:0]        acc_sum;

  assign acc_raddr = s1_vld_r ? s1_v_r : ctl.rd_v;

  // vector store: one write and one read per cycle
  always_ff @(posedge clk) begin
    if (ctl.vs_we) begin
      vs_mem[ctl.vs_waddr] <= ctl.vs_wdata;
    end
    vs_q <= vs_mem[{ctl.mac_v, ctl.mac_fi}];
  end

  always_ff @(posedge clk) begin
    acc_q     <= acc_mem[acc_raddr];
    acc_q_vld <= acc_vld_r[acc_raddr];
    if (s2_vld_r) begin
      acc_mem[s2_v_r] <= acc_sum;
    end
  end

  assign acc_sum = (acc_q_vld ? acc_q : '0) + ACC_W'(prod_r);
  assign acc_rd  = acc_q_vld ? acc_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      acc_vld_r <= '0;
    end else if (s2_vld_r) begin
      acc_vld_r[s2_v_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.mac_issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_v_r <= ctl.mac_v;
    x_r    <= ctl.mac_x;
    s2_v_r <= s1_v_r;
    prod_r <= vs_q * x_r;
  end

  assign pipe_busy = s1_vld_r | s2_vld_r;

endmodule

[hdl/svmsk_kernel_unit.sv]
// ----------------------------------------------------------------------------
// svmsk_kernel_unit
// Coefficient store, kernel argument, tanh interpolation and term sum.
// ----------------------------------------------------------------------------
module svmsk_kernel_unit import svmsk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kern_ctl_t               ctl,
  input  logic signed [ACC_W-1:0] acc_rd,
  input  logic [31:0]             gamma,
  input  logic signed [31:0]      kernel_offset,
  input  logic signed [31:0]      bias,
  output logic signed [SUM_W-1:0] sum,
  output logic                    pipe_busy
);

  logic [31:0]             coef_mem [0:MAX_VECTORS-1];
  logic signed [31:0]      coef_q;

  logic [6:0]              vld_r;
  logic signed [31:0]      c2_r, c3_r, c4_r, c5_r, c6_r;
  logic                    n2_r;
  logic [55:0]             ph_r, pl_r;
  logic signed [58:0]      s_r;
  logic [16:0]             lo_r, hi_r, lo5_r;
  logic [FRAC_W-1:0]       fr_r;
  logic                    big_r, big5_r, sn_r, sn5_r;
  logic signed [30:0]      m_r;
  logic signed [17:0]      y_r;
  logic signed [49:0]      term_r;
  logic signed [SUM_W-1:0] sum_r;

  logic                    k1_neg;
  logic [ACC_W-1:0]        k1_mag;
  logic [56:0]             k2_p;
  logic signed [58:0]      k2_s;
  logic [58:0]             k3_a;
  logic [TIDX_W-1:0]       k3_idx;
  logic [TIDX_W:0]         k3_idx1;
  logic signed [17:0]      k4_d;
  logic signed [17:0]      k5_y;

  always_ff @(posedge clk) begin
    if (ctl.coef_we) begin
      coef_mem[ctl.coef_waddr] <= ctl.coef_wdata;
    end
    coef_q <= coef_mem[ctl.v];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], ctl.issue};
    end
  end

  // magnitude of the accumulator split into two 24-bit halves
  assign k1_neg = acc_rd[ACC_W-1];
  assign k1_mag = k1_neg ? ACC_W'(-acc_rd) : ACC_W'(acc_rd);

  // round the gamma product back to Q16.16, restore sign, add r
  assign k2_p = 57'(ph_r) + 57'((pl_r + 56'h800000) >> 24);
  assign k2_s = (n2_r ? -$signed({2'b00, k2_p}) : $signed({2'b00, k2_p}))
                + 59'(kernel_offset);

  assign k3_a    = s_r[58] ? 59'(-s_r) : 59'(s_r);
  assign k3_idx  = k3_a[18:FRAC_W];
  assign k3_idx1 = {1'b0, k3_idx} + 1'b1;

  assign k4_d = $signed({1'b0, hi_r}) - $signed({1'b0, lo_r});

  assign k5_y = big5_r ? 18'sd65536
                       : $signed({1'b0, lo5_r}) + 18'((m_r + 31'sd1024) >>> FRAC_W);

  always_ff @(posedge clk) begin
    // stage 1
    n2_r <= k1_neg;
    ph_r <= gamma * k1_mag[47:24];
    pl_r <= gamma * k1_mag[23:0];
    c2_r <= coef_q;
    // stage 2
    s_r  <= k2_s;
    c3_r <= c2_r;
    // stage 3
    big_r <= (k3_a[58:19] != '0);
    sn_r  <= s_r[58];
    lo_r  <= TANH_TBL[k3_idx];
    hi_r  <= TANH_TBL[k3_idx1];
    fr_r  <= k3_a[FRAC_W-1:0];
    c4_r  <= c3_r;
    // stage 4
    m_r    <= k4_d * $signed({1'b0, fr_r});
    lo5_r  <= lo_r;
    big5_r <= big_r;
    sn5_r  <= sn_r;
    c5_r   <= c4_r;
    // stage 5
    y_r  <= sn5_r ? -k5_y : k5_y;
    c6_r <= c5_r;
    // stage 6
    term_r <= c6_r * y_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      sum_r <= SUM_W'(bias) <<< 16;
    end else if (vld_r[6]) begin
      sum_r <= sum_r + SUM_W'(term_r);
    end
  end

  assign sum       = sum_r;
  assign pipe_busy = |vld_r;

endmodule

[hdl/svm_sigmoid_kernel_decision.sv]
// ----------------------------------------------------------------------------
// svm_sigmoid_kernel_decision
// Sigmoid-kernel SVM decision value over up to 64 stored support vectors.
// ----------------------------------------------------------------------------
// A load item (vector element or coefficient) is written in the cycle it is
// accepted and busy stays low, so loads may stream one per cycle. A feature
// item walks the active support vectors through the accumulator memory, one
// read-modify-write per cycle with busy high; the active count is the NVEC
// register capped at 64. A feature marked last then streams the accumulators
// and coefficients through the tanh pipeline, and the decision is presented
// on out_item for exactly one cycle with out_valid; the receiver cannot
// stall, so sample it then. The accumulators read as zero after reset and
// after each decision. The user must make configuration writes through the
// APB port only while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module svm_sigmoid_kernel_decision import svmsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FEAT_W-1:0]  fi_r;
  logic signed [15:0] x_r;
  logic               last_r;

  logic signed [31:0] bias_r, offset_r;
  logic [31:0]        gamma_r;
  logic [6:0]         nvec_r;
  logic [CNT_W-1:0]   n_act;

  logic               accept, cfg_wr;
  logic               dot_busy, kern_busy;
  logic signed [ACC_W-1:0] acc_rd;
  logic signed [SUM_W-1:0] sum;
  dot_ctl_t           dctl;
  kern_ctl_t          kctl;

  logic               emit;
  logic signed [SUM_W-17:0] q;
  logic               q_hi, q_lo;
  logic               out_valid_r;
  out_item_t          out_item_r;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // cap the active count at the store depth
  assign n_act = (nvec_r > 7'(MAX_VECTORS)) ? CNT_W'(MAX_VECTORS) : CNT_W'(nvec_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= '0;
      gamma_r  <= 32'd65536;
      offset_r <= '0;
      nvec_r   <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BIAS:   bias_r   <= pwdata;
        REG_GAMMA:  gamma_r  <= pwdata;
        REG_OFFSET: offset_r <= pwdata;
        REG_NVEC:   nvec_r   <= pwdata[6:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BIAS:   prdata = bias_r;
      REG_GAMMA:  prdata = gamma_r;
      REG_OFFSET: prdata = offset_r;
      REG_NVEC:   prdata = {25'd0, nvec_r};
      default:    prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.opcode == OP_FEATURE) begin
          cnt_nxt   = '0;
          state_nxt = (n_act == '0) ? ST_MAC_WAIT : ST_MAC;
        end
      end
      ST_MAC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == n_act - 1'b1) begin
          state_nxt = ST_MAC_WAIT;
        end
      end
      ST_MAC_WAIT: begin
        if (!dot_busy) begin
          cnt_nxt = '0;
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = (n_act == '0) ? ST_DEC_WAIT : ST_DEC;
          end
        end
      end
      ST_DEC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == n_act - 1'b1) begin
          state_nxt = ST_DEC_WAIT;
        end
      end
      ST_DEC_WAIT: begin
        if (!kern_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    busy = (state_r != ST_IDLE);
    emit = (state_r == ST_DEC_WAIT) && !kern_busy;

    dctl           = '0;
    dctl.vs_we     = accept && in_item.opcode == OP_LOAD_VEC;
    dctl.vs_waddr  = {in_item.vector_index, in_item.feature_index};
    dctl.vs_wdata  = in_item.value[15:0];
    dctl.mac_issue = (state_r == ST_MAC);
    dctl.mac_v     = cnt_r[VEC_W-1:0];
    dctl.mac_fi    = fi_r;
    dctl.mac_x     = x_r;
    dctl.rd_v      = cnt_r[VEC_W-1:0];
    dctl.clear     = emit;

    kctl            = '0;
    kctl.coef_we    = accept && in_item.opcode == OP_LOAD_COEF;
    kctl.coef_waddr = in_item.vector_index;
    kctl.coef_wdata = in_item.value;
    kctl.init       = (state_r == ST_MAC_WAIT) && !dot_busy;
    kctl.issue      = (state_r == ST_DEC);
    kctl.v          = cnt_r[VEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // hold the feature item for the walk over the vectors
  always_ff @(posedge clk) begin
    if (accept) begin
      fi_r   <= in_item.feature_index;
      x_r    <= in_item.value[15:0];
      last_r <= in_item.last;
    end
  end

  svmsk_dot_unit u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dctl),
    .acc_rd    (acc_rd),
    .pipe_busy (dot_busy)
  );

  svmsk_kernel_unit u_kern (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (kctl),
    .acc_rd        (acc_rd),
    .gamma         (gamma_r),
    .kernel_offset (offset_r),
    .bias          (bias_r),
    .sum           (sum),
    .pipe_busy     (kern_busy)
  );

  // round half up to Q16.16, then saturate
  assign q    = (SUM_W-16)'(SUM_W'(sum + SUM_W'(32768)) >>> 16);
  assign q_hi = (q > $signed(40'sh007FFFFFFF));
  assign q_lo = (q < $signed(-40'sh0080000000));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.overflow <= q_hi | q_lo;
      if (q_hi) begin
        out_item_r.decision <= 32'sh7FFFFFFF;
      end else if (q_lo) begin
        out_item_r.decision <= 32'sh80000000;
      end else begin
        out_item_r.decision <= q[31:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // drop a result only out of the final drain
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DEC_WAIT))
    else $error("result without a decision pass");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_IDLE)
    else $error("result while still busy");

  a_feat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.opcode == OP_FEATURE) |=> busy)
    else $error("feature transfer did not raise busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(dctl.mac_issue && kctl.issue))
    else $error("accumulate and decision passes overlap");

endmodule
